// ----- design/ray_disk_pkg.sv -----
// ----------------------------------------------------------------------------
// ray_disk_pkg
// shared widths and register indexes for the ray versus disk intersection unit
// ----------------------------------------------------------------------------
package ray_disk_pkg;

    localparam int FIELD_W   = 32;   // width of every coordinate field
    localparam int RADIUS_W  = 31;   // width of the radius register
    localparam int EPS_W     = 17;   // width of the epsilon register
    localparam int CFG_IDX_W = 4;    // register index width on the config port

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 4'd0,
        CFG_CENTER_Y     = 4'd1,
        CFG_CENTER_Z     = 4'd2,
        CFG_DISK_RADIUS  = 4'd3,
        CFG_NORMAL_X     = 4'd4,
        CFG_NORMAL_Y     = 4'd5,
        CFG_NORMAL_Z     = 4'd6,
        CFG_MIN_DISTANCE = 4'd7
    } cfg_idx_t;

endpackage

// ----- design/ray_disk_intersection_unit.sv -----
// ----------------------------------------------------------------------------
// ray_disk_intersection_unit
// pipelined ray versus disk test, one ray per clock unless the output stalls, fixed point throughout
// ----------------------------------------------------------------------------
// Takes one ray (origin, direction) per clock and returns one result per ray,
// in order. t = ((C - O) . N) / (D . N); a hit needs t above min_distance and
// the point O + t*D strictly inside the disk; with no hit every output field
// is zero. Fields are Q16.16 at the default FRAC_BITS; the restoring divider
// resolves one quotient bit per stage over 32 + FRAC_BITS stages. Throughput
// is one ray per cycle; the whole pipeline holds while a result waits at the
// output and m_tready is low. Configuration
// is written through cfg_* and takes effect for rays accepted afterwards; it
// should only be written while no ray is in flight.
module ray_disk_intersection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ray_disk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ray_disk_pkg::FIELD_W-1:0]     cfg_data,
    // ray input: origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [6*ray_disk_pkg::FIELD_W-1:0]   s_tdata,
    // result: distance, hit_x, hit_y, hit_z
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [4*ray_disk_pkg::FIELD_W-1:0]   m_tdata,
    // result flag: is_hit
    output logic                                 m_tuser
);
    import ray_disk_pkg::*;

    localparam int DW = FIELD_W + FRAC_BITS;   // dividend and quotient width

    typedef logic [2:0][FIELD_W-1:0] vec_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic               neg;
        vec_t               o;
        vec_t               d;
        logic [DW-1:0]      dvd;
        logic [DW-1:0]      quo;
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] den;
    } div_t;

    // config registers
    logic signed [FIELD_W-1:0] c_reg [3];
    logic signed [FIELD_W-1:0] n_reg [3];
    logic [RADIUS_W-1:0]       radius_reg;
    logic [EPS_W-1:0]          eps_reg;
    logic [2*RADIUS_W-1:0]     r_sq_reg;

    // global advance: everything moves unless the output holds a stalled result
    logic adv;
    logic out_valid_reg;
    logic out_hit_reg;
    logic [4*FIELD_W-1:0] out_data_reg;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg[0]   <= FIELD_W'(1) << FRAC_BITS;
            c_reg[1]   <= FIELD_W'(1) << FRAC_BITS;
            c_reg[2]   <= FIELD_W'(1) << FRAC_BITS;
            n_reg[0]   <= '0;
            n_reg[1]   <= '0;
            n_reg[2]   <= FIELD_W'(1) << FRAC_BITS;
            radius_reg <= RADIUS_W'(3) << FRAC_BITS;
            eps_reg    <= EPS_W'(7);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CENTER_X:     c_reg[0]   <= cfg_data;
                CFG_CENTER_Y:     c_reg[1]   <= cfg_data;
                CFG_CENTER_Z:     c_reg[2]   <= cfg_data;
                CFG_DISK_RADIUS:  radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_NORMAL_X:     n_reg[0]   <= cfg_data;
                CFG_NORMAL_Y:     n_reg[1]   <= cfg_data;
                CFG_NORMAL_Z:     n_reg[2]   <= cfg_data;
                CFG_MIN_DISTANCE: eps_reg    <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // radius squared, refreshed every cycle from the static register
    always_ff @(posedge aclk) begin
        r_sq_reg <= radius_reg * radius_reg;
    end

    // ------------------------------------------------------------------
    // stage a: centre minus origin, direction times normal
    // ------------------------------------------------------------------
    logic                      a_valid_reg, a_bad_reg;
    vec_t                      a_o_reg, a_d_reg;
    logic signed [FIELD_W:0]   a_diff_reg [3];
    logic signed [2*FIELD_W-1:0] a_dn_reg [3];

    logic signed [FIELD_W:0]   a_diff_next [3];
    logic                      a_bad_next;

    always_comb begin
        a_bad_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a_diff_next[i] = (FIELD_W+1)'(c_reg[i])
                           - (FIELD_W+1)'($signed(s_tdata[i*FIELD_W +: FIELD_W]));
            if (a_diff_next[i][FIELD_W] != a_diff_next[i][FIELD_W-1])
                a_bad_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_bad_reg <= a_bad_next;
            for (int i = 0; i < 3; i++) begin
                a_o_reg[i]    <= s_tdata[i*FIELD_W +: FIELD_W];
                a_d_reg[i]    <= s_tdata[(i+3)*FIELD_W +: FIELD_W];
                a_diff_reg[i] <= a_diff_next[i];
                a_dn_reg[i]   <= $signed(s_tdata[(i+3)*FIELD_W +: FIELD_W]) * n_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage b: difference times normal
    // ------------------------------------------------------------------
    logic                        b_valid_reg, b_bad_reg;
    vec_t                        b_o_reg, b_d_reg;
    logic signed [2*FIELD_W:0]   b_cn_reg [3];
    logic signed [2*FIELD_W-1:0] b_dn_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_bad_reg <= a_bad_reg;
            b_o_reg   <= a_o_reg;
            b_d_reg   <= a_d_reg;
            for (int i = 0; i < 3; i++) begin
                b_cn_reg[i] <= a_diff_reg[i] * n_reg[i];
                b_dn_reg[i] <= a_dn_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage c: floor shift and sum into numerator and denominator
    // ------------------------------------------------------------------
    localparam int SW = 2*FIELD_W + 4;

    logic signed [SW-1:0] num_w, den_w;
    logic                 num_ok, den_ok;

    always_comb begin
        num_w = (SW'(b_cn_reg[0]) >>> FRAC_BITS) + (SW'(b_cn_reg[1]) >>> FRAC_BITS)
              + (SW'(b_cn_reg[2]) >>> FRAC_BITS);
        den_w = (SW'(b_dn_reg[0]) >>> FRAC_BITS) + (SW'(b_dn_reg[1]) >>> FRAC_BITS)
              + (SW'(b_dn_reg[2]) >>> FRAC_BITS);
        num_ok = (num_w[SW-1:FIELD_W-1] == '0) || (num_w[SW-1:FIELD_W-1] == '1);
        den_ok = (den_w[SW-1:FIELD_W-1] == '0) || (den_w[SW-1:FIELD_W-1] == '1);
    end

    logic                      c_valid_reg, c_bad_reg;
    vec_t                      c_o_reg, c_d_reg;
    logic signed [FIELD_W-1:0] c_num_reg, c_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_bad_reg <= b_bad_reg || !num_ok || !den_ok || (den_w == '0);
            c_o_reg   <= b_o_reg;
            c_d_reg   <= b_d_reg;
            c_num_reg <= num_w[FIELD_W-1:0];
            c_den_reg <= den_w[FIELD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // divider: magnitudes in, one quotient bit per stage
    // ------------------------------------------------------------------
    div_t div_reg  [DW+1];
    div_t div_next [DW+1];

    logic [FIELD_W-1:0] abs_num, abs_den;

    always_comb begin
        abs_num = c_num_reg[FIELD_W-1] ? FIELD_W'(-c_num_reg) : FIELD_W'(c_num_reg);
        abs_den = c_den_reg[FIELD_W-1] ? FIELD_W'(-c_den_reg) : FIELD_W'(c_den_reg);

        div_next[0].valid = c_valid_reg;
        div_next[0].bad   = c_bad_reg;
        div_next[0].neg   = c_num_reg[FIELD_W-1] ^ c_den_reg[FIELD_W-1];
        div_next[0].o     = c_o_reg;
        div_next[0].d     = c_d_reg;
        div_next[0].dvd   = DW'(abs_num) << FRAC_BITS;
        div_next[0].quo   = '0;
        div_next[0].rem   = '0;
        div_next[0].den   = abs_den;

        for (int k = 0; k < DW; k++) begin
            logic [FIELD_W:0] trial;
            logic             fit;
            trial = {div_reg[k].rem, div_reg[k].dvd[DW-1]};
            fit   = (trial >= {1'b0, div_reg[k].den});
            div_next[k+1]     = div_reg[k];
            div_next[k+1].dvd = {div_reg[k].dvd[DW-2:0], 1'b0};
            div_next[k+1].quo = {div_reg[k].quo[DW-2:0], fit};
            div_next[k+1].rem = fit ? FIELD_W'(trial - {1'b0, div_reg[k].den})
                                    : trial[FIELD_W-1:0];
        end
    end

    // valid bits reset, data fields only follow the advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DW; k++) div_reg[k].valid <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k <= DW; k++) div_reg[k].valid <= div_next[k].valid;
        end
        if (adv) begin
            for (int k = 0; k <= DW; k++) begin
                div_reg[k].bad <= div_next[k].bad;
                div_reg[k].neg <= div_next[k].neg;
                div_reg[k].o   <= div_next[k].o;
                div_reg[k].d   <= div_next[k].d;
                div_reg[k].dvd <= div_next[k].dvd;
                div_reg[k].quo <= div_next[k].quo;
                div_reg[k].rem <= div_next[k].rem;
                div_reg[k].den <= div_next[k].den;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage e: signed quotient, range and epsilon checks
    // ------------------------------------------------------------------
    logic [DW-1:0]             q;
    logic                      q_ok;
    logic signed [FIELD_W-1:0] t_w;

    always_comb begin
        q    = div_reg[DW].quo;
        q_ok = div_reg[DW].neg ? (q <= (DW'(1) << (FIELD_W-1)))
                               : (q <  (DW'(1) << (FIELD_W-1)));
        t_w  = div_reg[DW].neg ? FIELD_W'(-q[FIELD_W-1:0]) : q[FIELD_W-1:0];
    end

    logic                      e_valid_reg, e_bad_reg;
    vec_t                      e_o_reg, e_d_reg;
    logic signed [FIELD_W-1:0] e_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= div_reg[DW].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_bad_reg <= div_reg[DW].bad || !q_ok
                      || (t_w <= $signed({{(FIELD_W-EPS_W){1'b0}}, eps_reg}));
            e_o_reg   <= div_reg[DW].o;
            e_d_reg   <= div_reg[DW].d;
            e_t_reg   <= t_w;
        end
    end

    // ------------------------------------------------------------------
    // stage f: t times direction
    // ------------------------------------------------------------------
    logic                        f_valid_reg, f_bad_reg;
    vec_t                        f_o_reg;
    logic signed [FIELD_W-1:0]   f_t_reg;
    logic signed [2*FIELD_W-1:0] f_td_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_bad_reg <= e_bad_reg;
            f_o_reg   <= e_o_reg;
            f_t_reg   <= e_t_reg;
            for (int i = 0; i < 3; i++)
                f_td_reg[i] <= e_t_reg * $signed(e_d_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // stage g: hit point, offset from centre, per-axis rim check
    // ------------------------------------------------------------------
    localparam int PW = 2*FIELD_W + 2;

    logic signed [PW-1:0]     p_w  [3];
    logic signed [FIELD_W:0]  off_w [3];
    logic [FIELD_W:0]         aoff_w [3];
    logic                     g_bad_next;

    always_comb begin
        g_bad_next = f_bad_reg;
        for (int i = 0; i < 3; i++) begin
            p_w[i]    = PW'($signed(f_o_reg[i])) + (PW'(f_td_reg[i]) >>> FRAC_BITS);
            off_w[i]  = (FIELD_W+1)'($signed(p_w[i][FIELD_W-1:0]))
                      - (FIELD_W+1)'(c_reg[i]);
            aoff_w[i] = off_w[i][FIELD_W] ? (FIELD_W+1)'(-off_w[i])
                                          : (FIELD_W+1)'(off_w[i]);
            if (!((p_w[i][PW-1:FIELD_W-1] == '0) || (p_w[i][PW-1:FIELD_W-1] == '1)))
                g_bad_next = 1'b1;
            if (aoff_w[i] >= (FIELD_W+1)'(radius_reg))
                g_bad_next = 1'b1;
        end
    end

    logic                 g_valid_reg, g_bad_reg;
    logic [FIELD_W-1:0]   g_t_reg;
    vec_t                 g_p_reg;
    logic [RADIUS_W-1:0]  g_aoff_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_bad_reg <= g_bad_next;
            g_t_reg   <= f_t_reg;
            for (int i = 0; i < 3; i++) begin
                g_p_reg[i]    <= p_w[i][FIELD_W-1:0];
                g_aoff_reg[i] <= aoff_w[i][RADIUS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage h: squared offsets
    // ------------------------------------------------------------------
    logic                  h_valid_reg, h_bad_reg;
    logic [FIELD_W-1:0]    h_t_reg;
    vec_t                  h_p_reg;
    logic [2*RADIUS_W-1:0] h_sq_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (adv) begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_bad_reg <= g_bad_reg;
            h_t_reg   <= g_t_reg;
            h_p_reg   <= g_p_reg;
            for (int i = 0; i < 3; i++)
                h_sq_reg[i] <= g_aoff_reg[i] * g_aoff_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // output: distance squared against radius squared, result register
    // ------------------------------------------------------------------
    logic [2*RADIUS_W+1:0] dist2;
    logic                  hit;
    logic [4*FIELD_W-1:0]  out_data_next;

    always_comb begin
        dist2 = (2*RADIUS_W+2)'(h_sq_reg[0]) + (2*RADIUS_W+2)'(h_sq_reg[1])
              + (2*RADIUS_W+2)'(h_sq_reg[2]);
        hit   = !h_bad_reg && (dist2 < (2*RADIUS_W+2)'(r_sq_reg));
        out_data_next = '0;
        if (hit) begin
            out_data_next = {h_p_reg[2], h_p_reg[1], h_p_reg[0], h_t_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hit_reg  <= hit;
            out_data_reg <= out_data_next;
        end
    end

endmodule
